/* src/bitmap_glyph_row_generator_macros.svh */
// Assertion macros used by the glyph row generator sequencer.
`ifndef BITMAP_GLYPH_ROW_GENERATOR_MACROS_SVH
`define BITMAP_GLYPH_ROW_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BGR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bgr assertion failed (same cycle)");
// next-cycle implication
`define BGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bgr assertion failed (next cycle)");
`else
`define BGR_ASSERT_IMPL(lbl, ante, cons)
`define BGR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/bgr_pkg.sv */
// Shared types and constants of the glyph row generator.
package bgr_pkg;

    localparam int FONT_BYTES_DEF   = 8192;
    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 32;

    // config register widths
    localparam int GW_W = 5;
    localparam int GH_W = 6;
    localparam int FL_W = 14;

    // stream field widths
    localparam int CODE_W   = 16;
    localparam int COLOR_W  = 32;
    localparam int LADDR_W  = 13;
    localparam int LBYTE_W  = 8;
    localparam int ROW_W    = 5;
    localparam int MASK_W   = 16;
    localparam int STATUS_W = 3;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_AW      = 4;
    localparam int CFG_DW      = 32;

    // datapath widths
    localparam int ROW_CNT_W = $clog2(MAX_GLYPH_HEIGHT);
    localparam int OFF_W     = ROW_CNT_W + $clog2(MAX_GLYPH_WIDTH + 1);
    localparam int PROD1_W   = CODE_W + GW_W;
    localparam int PROD2_W   = PROD1_W + GH_W;
    localparam int BYTE_SHIFT = 3;
    localparam int BASE_W    = PROD2_W - BYTE_SHIFT;
    localparam int ADDR_W    = BASE_W + 1;
    localparam int BYTE_BITS = 8;

    localparam logic [CODE_W-1:0] BLANK_LIMIT = 16'h0020;

    typedef enum logic [0:0] {
        OP_RENDER = 1'b0,
        OP_LOAD   = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BLANK      = 3'd1,
        ST_CHAR_RANGE = 3'd2,
        ST_ROW_RANGE  = 3'd3,
        ST_LOADED     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_MUL1 = 3'd1,
        S_MUL2 = 3'd2,
        S_ROWS = 3'd3,
        S_LOAD = 3'd4
    } t_state;

    typedef enum logic [1:0] {
        REG_GLYPH_WIDTH  = 2'd0,
        REG_GLYPH_HEIGHT = 2'd1,
        REG_FONT_LENGTH  = 2'd2
    } t_reg;

    typedef struct packed {
        logic [GW_W-1:0] glyph_width;
        logic [GH_W-1:0] glyph_height;
        logic [FL_W-1:0] font_length;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [MASK_W-1:0]  pixel_mask;
        logic [COLOR_W-1:0] pixel_color;
        t_status            status;
        logic               last;
    } t_row_out;

endpackage

/* src/bgr_font_mem.sv */
// Font store: one write port, one registered read port.
module bgr_font_mem import bgr_pkg::*; #(
    parameter int FONT_BYTES = FONT_BYTES_DEF,
    parameter int MEM_AW     = $clog2(FONT_BYTES_DEF)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [MEM_AW-1:0]  i_waddr,
    input  logic [BYTE_BITS-1:0] i_wdata,
    input  logic               i_re,
    input  logic [MEM_AW-1:0]  i_raddr,
    output logic [BYTE_BITS-1:0] o_rdata
);

    logic [BYTE_BITS-1:0] r_mem [FONT_BYTES];
    logic [BYTE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bgr_seq.sv */
// Row sequencer: glyph base multiply, per-row address, font read, output stage; also font byte loads.
`include "bitmap_glyph_row_generator_macros.svh"
module bgr_seq import bgr_pkg::*; #(
    parameter int FONT_BYTES = FONT_BYTES_DEF,
    parameter int MEM_AW     = $clog2(FONT_BYTES_DEF)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_in_op,
    input  logic [CODE_W-1:0]    i_in_code,
    input  logic [COLOR_W-1:0]   i_in_color,
    input  logic [LADDR_W-1:0]   i_in_laddr,
    input  logic [LBYTE_W-1:0]   i_in_lbyte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_row_out             o_out,
    output logic                 o_mem_we,
    output logic [MEM_AW-1:0]    o_mem_waddr,
    output logic [BYTE_BITS-1:0] o_mem_wdata,
    output logic                 o_mem_re,
    output logic [MEM_AW-1:0]    o_mem_raddr,
    input  logic [BYTE_BITS-1:0] i_mem_rdata
);

    localparam int FB_W  = $clog2(FONT_BYTES + 1);
    localparam int CMP_W = (FB_W > FL_W) ? FB_W : FL_W;

    t_state r_state, n_state;

    logic in_accept;
    logic b_free;
    logic a_go;
    logic row_last;
    logic crange;
    logic rrange;
    logic addr_ok;
    t_status row_status;
    logic [ADDR_W-1:0] a_full;

    logic [GW_W-1:0]      w_clamp;
    logic [GH_W-1:0]      h_clamp;
    logic [FL_W-1:0]      len_clamp;
    logic [BYTE_BITS-1:0] colen_c;

    logic [CODE_W-1:0]    r_code;
    logic [COLOR_W-1:0]   r_color;
    logic [GW_W-1:0]      r_w;
    logic [GH_W-1:0]      r_h;
    logic [FL_W-1:0]      r_len;
    logic [BYTE_BITS-1:0] r_colen;
    logic                 r_blank;
    logic [PROD1_W-1:0]   r_prod1;
    logic [BASE_W-1:0]    r_base;
    logic [ROW_CNT_W-1:0] r_row, n_row;
    logic [OFF_W-1:0]     r_off, n_off;

    logic                 r_b_valid;
    logic [ROW_CNT_W-1:0] r_b_row;
    logic [COLOR_W-1:0]   r_b_color;
    t_status              r_b_status;
    logic                 r_b_last;
    logic [BYTE_BITS-1:0] r_b_colen;

    // register clamping
    always_comb begin
        if (i_cfg.glyph_width == '0) begin
            w_clamp = GW_W'(1);
        end else if ((GW_W+1)'(i_cfg.glyph_width) > (GW_W+1)'(MAX_GLYPH_WIDTH)) begin
            w_clamp = GW_W'(MAX_GLYPH_WIDTH);
        end else begin
            w_clamp = i_cfg.glyph_width;
        end
        if (i_cfg.glyph_height == '0) begin
            h_clamp = GH_W'(1);
        end else if ((GH_W+1)'(i_cfg.glyph_height) > (GH_W+1)'(MAX_GLYPH_HEIGHT)) begin
            h_clamp = GH_W'(MAX_GLYPH_HEIGHT);
        end else begin
            h_clamp = i_cfg.glyph_height;
        end
        if (CMP_W'(i_cfg.font_length) > CMP_W'(FONT_BYTES)) begin
            len_clamp = FL_W'(FONT_BYTES);
        end else begin
            len_clamp = i_cfg.font_length;
        end
        // only the first byte's worth of columns can light
        for (int n = 0; n < BYTE_BITS; n++) begin
            colen_c[n] = (GW_W+1)'(n) < (GW_W+1)'(w_clamp);
        end
    end

    assign in_accept = i_in_valid & o_in_ready;
    assign addr_ok   = CMP_W'(i_in_laddr) < CMP_W'(FONT_BYTES);

    // per-row address and status
    always_comb begin
        a_full   = ADDR_W'(r_base) + ADDR_W'(r_off >> BYTE_SHIFT);
        crange   = r_base >= BASE_W'(r_len);
        rrange   = a_full >= ADDR_W'(r_len);
        row_last = (GH_W'(r_row) + GH_W'(1)) == r_h;
        if (r_blank) begin
            row_status = ST_BLANK;
        end else if (crange) begin
            row_status = ST_CHAR_RANGE;
        end else if (rrange) begin
            row_status = ST_ROW_RANGE;
        end else begin
            row_status = ST_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_op == OP_LOAD) ? S_LOAD : S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_ROWS;
            S_ROWS: begin
                if (a_go && row_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                if (a_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        b_free      = !r_b_valid || i_out_ready;
        a_go        = b_free && ((r_state == S_ROWS) || (r_state == S_LOAD));
        o_mem_re    = a_go && (r_state == S_ROWS) && (row_status == ST_OK);
        o_mem_raddr = MEM_AW'(a_full);
        o_mem_we    = in_accept && (i_in_op == OP_LOAD) && addr_ok;
        o_mem_waddr = MEM_AW'(i_in_laddr);
        o_mem_wdata = i_in_lbyte;
        n_row       = r_row;
        n_off       = r_off;
        if (a_go && (r_state == S_ROWS)) begin
            if (row_last) begin
                n_row = '0;
                n_off = '0;
            end else begin
                n_row = r_row + ROW_CNT_W'(1);
                n_off = r_off + OFF_W'(r_w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_off     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_off   <= n_off;
            if (a_go) begin
                r_b_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_code  <= i_in_code;
            r_color <= i_in_color;
            r_w     <= w_clamp;
            r_h     <= h_clamp;
            r_len   <= len_clamp;
            r_colen <= colen_c;
            r_blank <= i_in_code <= BLANK_LIMIT;
        end
        if (r_state == S_MUL1) begin
            r_prod1 <= PROD1_W'(r_code) * PROD1_W'(r_w);
        end
        if (r_state == S_MUL2) begin
            r_base <= BASE_W'((PROD2_W'(r_prod1) * PROD2_W'(r_h)) >> BYTE_SHIFT);
        end
        if (a_go) begin
            if (r_state == S_ROWS) begin
                r_b_row    <= r_row;
                r_b_color  <= r_color;
                r_b_status <= row_status;
                r_b_last   <= row_last;
                r_b_colen  <= r_colen;
            end else begin
                r_b_row    <= '0;
                r_b_color  <= '0;
                r_b_status <= ST_LOADED;
                r_b_last   <= 1'b1;
                r_b_colen  <= '0;
            end
        end
    end

    // bit 7 of the font byte lights column 0
    always_comb begin
        o_out_valid       = r_b_valid;
        o_out.row_index   = ROW_W'(r_b_row);
        o_out.pixel_color = r_b_color;
        o_out.status      = r_b_status;
        o_out.last        = r_b_last;
        o_out.pixel_mask  = '0;
        for (int n = 0; n < BYTE_BITS; n++) begin
            o_out.pixel_mask[n] = r_b_colen[n] & i_mem_rdata[BYTE_BITS-1-n]
                                  & (r_b_status == ST_OK);
        end
    end

    `BGR_ASSERT_NEXT(a_load_state, in_accept && (i_in_op == OP_LOAD), r_state == S_LOAD)
    `BGR_ASSERT_IMPL(a_idle_row_zero, r_state == S_IDLE, (r_row == '0) && (r_off == '0))
    `BGR_ASSERT_IMPL(a_read_in_range, o_mem_re, a_full < ADDR_W'(r_len))
    `BGR_ASSERT_NEXT(a_stall_hold, r_b_valid && !i_out_ready, r_b_valid && $stable(r_b_row))

endmodule

/* src/bitmap_glyph_row_generator.sv */
// Top level of the bitmap glyph row generator: config registers and stream ports.
// Input stream: tuser selects render (0) or load (1). A load writes one font
// byte and answers with one transfer, status "load done". A render answers
// with glyph_height row transfers, tlast on the final row.
// Configuration: APB writes glyph_width, glyph_height and font_length at byte
// addresses 0, 4 and 8; write only while the block is idle.
// Sequence: a render goes from its accept through the multiply states S_MUL1
// and S_MUL2 for the glyph base, then one row per cycle while the output is
// not stalled, through the single font store read port, each row registered
// in the output stage as its font byte is read. A load answers from S_LOAD.
// The last row may still wait on the output while the next item is taken.
// Reset: registers return to width 8, height 16, length 0 and no result is
// pending; font store contents are undefined and must be loaded before use.
// Receiver stall: the pending row holds on the output and the sequencer
// waits before issuing the next font read.
module bitmap_glyph_row_generator import bgr_pkg::*; #(
    parameter int FONT_BYTES = FONT_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tdata: char_code[15:0], color[47:16], load_address[60:48], load_byte[68:61]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation[0]
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: row_index[4:0], pixel_mask[20:5], pixel_color[52:21]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [STATUS_W-1:0]    m_axis_tuser,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [CFG_DW-1:0]      pwdata,
    output logic [CFG_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int MEM_AW  = $clog2(FONT_BYTES);
    localparam int OUT_PAD = OUT_TDATA_W - ROW_W - MASK_W - COLOR_W;

    t_cfg     r_cfg;
    t_row_out row_out;
    t_reg     reg_sel;
    logic     cfg_wr;

    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [BYTE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [MEM_AW-1:0]    mem_raddr;
    logic [BYTE_BITS-1:0] mem_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_width  <= GW_W'(8);
            r_cfg.glyph_height <= GH_W'(16);
            r_cfg.font_length  <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_GLYPH_WIDTH:  r_cfg.glyph_width  <= pwdata[GW_W-1:0];
                REG_GLYPH_HEIGHT: r_cfg.glyph_height <= pwdata[GH_W-1:0];
                REG_FONT_LENGTH:  r_cfg.font_length  <= pwdata[FL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_GLYPH_WIDTH:  prdata = CFG_DW'(r_cfg.glyph_width);
            REG_GLYPH_HEIGHT: prdata = CFG_DW'(r_cfg.glyph_height);
            REG_FONT_LENGTH:  prdata = CFG_DW'(r_cfg.font_length);
            default:          prdata = '0;
        endcase
    end

    bgr_seq #(
        .FONT_BYTES (FONT_BYTES),
        .MEM_AW     (MEM_AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_op     (s_axis_tuser),
        .i_in_code   (s_axis_tdata[15:0]),
        .i_in_color  (s_axis_tdata[47:16]),
        .i_in_laddr  (s_axis_tdata[60:48]),
        .i_in_lbyte  (s_axis_tdata[68:61]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (row_out),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    bgr_font_mem #(
        .FONT_BYTES (FONT_BYTES),
        .MEM_AW     (MEM_AW)
    ) u_font_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, row_out.pixel_color, row_out.pixel_mask,
                           row_out.row_index};
    assign m_axis_tuser = row_out.status;
    assign m_axis_tlast = row_out.last;

endmodule
